### hw/rtl/ntc_pkg.sv
// shared types and constants of the thermistor to temperature converter
package ntc_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_VREF_MV     = 3'd0,
      CSR_SERIES      = 3'd1,
      CSR_NOMINAL     = 3'd2,
      CSR_BETA        = 3'd3,
      CSR_OFFSET      = 3'd4,
      CSR_MAX_POWER   = 3'd5,
      CSR_MAX_CURRENT = 3'd6
   } csr_index_type;

   // register and datapath widths
   localparam int CSR_DATA_W = 20;
   localparam int VREF_W     = 13;
   localparam int UV_W       = 23;
   localparam int SQ_W       = 26;
   localparam int OHM_W      = 20;
   localparam int BETA_W     = 14;
   localparam int BETA_T_W   = 29;
   localparam int OFFSET_W   = 11;
   localparam int POWER_W    = 20;
   localparam int CURRENT_W  = 17;

   // ratio numerator and logarithm units
   localparam int NUM_W     = 43;
   localparam int LOG_N_W   = $clog2(NUM_W);
   localparam int FRAC_W    = 16;
   localparam int MANT_W    = 31;
   localparam int LOG_W     = LOG_N_W + FRAC_W;
   localparam int LOG_LAT   = LOG_N_W + FRAC_W;
   localparam int LR_W      = 24;
   localparam int CPROD_W   = 49;
   localparam int DEN_CALC_W = 50;
   localparam int DEN_W     = 48;
   localparam int TNUM_W    = BETA_T_W + 32;
   localparam int TEMP_W    = 64;

   // resistance stays below 2^30 ohms since the voltage is at least 10 mV
   localparam int RES_W     = 30;
   localparam int RSUM_W    = 31;
   localparam int RSQ_W     = 2 * RSUM_W;
   localparam int LHS_W     = SQ_W + RES_W;
   localparam int ILIM_W    = CURRENT_W + RSUM_W;
   localparam int PPART_W   = POWER_W + RSUM_W;
   localparam int RHS_W     = PPART_W + RSUM_W;

   // fixed constants
   localparam logic [23:0] LN2_T25_Q16 = 24'd13543790;
   localparam int RAIL_UV      = 10000;
   localparam int UV_PER_MV    = 1000;
   localparam int T25_CENTI    = 29815;
   localparam int KELVIN_CENTI = 27315;
   localparam int TEMP_LOW     = -4000;
   localparam int TEMP_HIGH    = 12500;

   // reset values of the configuration registers
   localparam logic [UV_W-1:0]      VREF_UV_RST  = 23'd3300000;
   localparam logic [SQ_W-1:0]      VREF_SQ_RST  = 26'd10890000;
   localparam logic [OHM_W-1:0]     SERIES_RST   = 20'd10000;
   localparam logic [OHM_W-1:0]     NOMINAL_RST  = 20'd10000;
   localparam logic [BETA_W-1:0]    BETA_RST     = 14'd3950;
   localparam logic [BETA_T_W-1:0]  BETA_T_RST   = 29'd117769250;
   localparam logic [OFFSET_W-1:0]  OFFSET_RST   = 11'd0;
   localparam logic [POWER_W-1:0]   POWER_RST    = 20'd1000;
   localparam logic [CURRENT_W-1:0] CURRENT_RST  = 17'd1000;

endpackage

### hw/rtl/ntc_delay.sv
// shift line of registers that keeps side data aligned with the pipeline
module ntc_delay #(
   parameter int W = 1,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [W-1:0] d_i,
   output logic [W-1:0] q_o
);

   logic [W-1:0] line_ff [0:D-1];

   // one stage per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         line_ff[0] <= d_i;
         for (int i = 1; i < D; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q_o = line_ff[D-1];

endmodule

### hw/rtl/ntc_div_cell.sv
// one restoring division step: brings down a dividend bit, yields a quotient bit
module ntc_div_cell #(
   parameter int NUMW = 8,
   parameter int DVW  = 8
) (
   input  logic            clock,
   input  logic [NUMW-1:0] work_i,
   input  logic [DVW-1:0]  rem_i,
   input  logic [DVW-1:0]  div_i,
   output logic [NUMW-1:0] work_o,
   output logic [DVW-1:0]  rem_o,
   output logic [DVW-1:0]  div_o
);

   logic [NUMW-1:0] work_ff, work_in;
   logic [DVW-1:0]  rem_ff, rem_in;
   logic [DVW-1:0]  div_ff;
   logic [DVW:0]    trial;
   logic [DVW:0]    diff;
   logic            ge;

   // trial subtract of the divisor
   always_comb begin
      trial   = {rem_i, work_i[NUMW-1]};
      diff    = trial - {1'b0, div_i};
      ge      = (trial >= {1'b0, div_i});
      rem_in  = ge ? diff[DVW-1:0] : trial[DVW-1:0];
      work_in = {work_i[NUMW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_i;
   end

   assign work_o = work_ff;
   assign rem_o  = rem_ff;
   assign div_o  = div_ff;

endmodule

### hw/rtl/ntc_divider.sv
// pipelined divider: a row of division cells, one quotient bit per cell
module ntc_divider #(
   parameter int NUMW = 8,
   parameter int DVW  = 8
) (
   input  logic            clock,
   input  logic [NUMW-1:0] num_i,
   input  logic [DVW-1:0]  div_i,
   output logic [NUMW-1:0] quo_o
);

   logic [NUMW-1:0] work [0:NUMW];
   logic [DVW-1:0]  rem  [0:NUMW];
   logic [DVW-1:0]  dv   [0:NUMW];

   assign work[0] = num_i;
   assign rem[0]  = '0;
   assign dv[0]   = div_i;

   // chain of cells, dividend bits shift out as quotient bits shift in
   for (genvar i = 0; i < NUMW; i++) begin : g_cell
      ntc_div_cell #(.NUMW(NUMW), .DVW(DVW)) u_cell (
         .clock  (clock),
         .work_i (work[i]),
         .rem_i  (rem[i]),
         .div_i  (dv[i]),
         .work_o (work[i+1]),
         .rem_o  (rem[i+1]),
         .div_o  (dv[i+1])
      );
   end

   assign quo_o = work[NUMW];

endmodule

### hw/rtl/ntc_log2_cell.sv
// one fraction bit of a base-2 logarithm by squaring the mantissa
module ntc_log2_cell #(
   parameter int FB = 0
) (
   input  logic                        clock,
   input  logic [ntc_pkg::MANT_W-1:0]  mant_i,
   input  logic [ntc_pkg::FRAC_W-1:0]  frac_i,
   input  logic [ntc_pkg::LOG_N_W-1:0] ipart_i,
   output logic [ntc_pkg::MANT_W-1:0]  mant_o,
   output logic [ntc_pkg::FRAC_W-1:0]  frac_o,
   output logic [ntc_pkg::LOG_N_W-1:0] ipart_o
);

   logic [2*ntc_pkg::MANT_W-1:0]  sq;
   logic [ntc_pkg::MANT_W:0]      top;
   logic [ntc_pkg::MANT_W-1:0]    mant_ff, mant_in;
   logic [ntc_pkg::FRAC_W-1:0]    frac_ff, frac_in;
   logic [ntc_pkg::LOG_N_W-1:0]   ipart_ff;

   // square, keep Q30, renormalize when it reaches two
   always_comb begin
      sq  = (2*ntc_pkg::MANT_W)'(mant_i) * (2*ntc_pkg::MANT_W)'(mant_i);
      top = sq[2*ntc_pkg::MANT_W-1:ntc_pkg::MANT_W-1];
      if (top[ntc_pkg::MANT_W]) begin
         mant_in = top[ntc_pkg::MANT_W:1];
         frac_in = frac_i | (ntc_pkg::FRAC_W'(1) << FB);
      end else begin
         mant_in = top[ntc_pkg::MANT_W-1:0];
         frac_in = frac_i;
      end
   end

   always_ff @(posedge clock) begin
      mant_ff  <= mant_in;
      frac_ff  <= frac_in;
      ipart_ff <= ipart_i;
   end

   assign mant_o  = mant_ff;
   assign frac_o  = frac_ff;
   assign ipart_o = ipart_ff;

endmodule

### hw/rtl/ntc_log2.sv
// base-2 logarithm in Q16: staged normalize, then a row of squaring cells
module ntc_log2 (
   input  logic                       clock,
   input  logic [ntc_pkg::NUM_W-1:0]  x_i,
   output logic [ntc_pkg::LOG_W-1:0]  log_o
);

   localparam int N = ntc_pkg::LOG_N_W;

   logic [ntc_pkg::NUM_W-1:0]   nx_ff [0:N-1];
   logic [N-1:0]                nc_ff [0:N-1];
   logic [ntc_pkg::MANT_W-1:0]  mant  [0:ntc_pkg::FRAC_W];
   logic [ntc_pkg::FRAC_W-1:0]  frac  [0:ntc_pkg::FRAC_W];
   logic [N-1:0]                ipart [0:ntc_pkg::FRAC_W];

   // leading zero removal, one shift size per stage
   for (genvar k = 0; k < N; k++) begin : g_norm
      localparam int SH = 1 << (N - 1 - k);
      logic [ntc_pkg::NUM_W-1:0] src;
      logic [N-1:0]              csrc;
      if (k == 0) begin : g_first
         assign src  = x_i;
         assign csrc = '0;
      end else begin : g_next
         assign src  = nx_ff[k-1];
         assign csrc = nc_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (src[ntc_pkg::NUM_W-1 -: SH] == '0) begin
            nx_ff[k] <= src << SH;
            nc_ff[k] <= csrc + N'(SH);
         end else begin
            nx_ff[k] <= src;
            nc_ff[k] <= csrc;
         end
      end
   end

   // integer part is the leading one position
   assign mant[0]  = nx_ff[N-1][ntc_pkg::NUM_W-1 -: ntc_pkg::MANT_W];
   assign frac[0]  = '0;
   assign ipart[0] = N'(ntc_pkg::NUM_W - 1) - nc_ff[N-1];

   // fraction bits, most significant first
   for (genvar i = 0; i < ntc_pkg::FRAC_W; i++) begin : g_sq
      ntc_log2_cell #(.FB(ntc_pkg::FRAC_W - 1 - i)) u_cell (
         .clock   (clock),
         .mant_i  (mant[i]),
         .frac_i  (frac[i]),
         .ipart_i (ipart[i]),
         .mant_o  (mant[i+1]),
         .frac_o  (frac[i+1]),
         .ipart_o (ipart[i+1])
      );
   end

   assign log_o = {ipart[ntc_pkg::FRAC_W], frac[ntc_pkg::FRAC_W]};

endmodule

### hw/rtl/ntc_thermistor_to_temperature_core.sv
// top level: thermistor divider sample to temperature, resistance and limit flags
//
// Fully pipelined: one sample may start in every cycle (busy never rises) and
// each sample gives exactly one result. For any ADC_BITS a sample passes the
// scaling front end (nine stages, of which four fold the scaled sample by the
// full-scale code and one corrects the quotient), the 22-stage logarithm units
// and the chain of 61 division cells for the Beta quotient; the 43-cell divider
// for the resistance runs alongside. Results appear for a single cycle on
// rsp_valid and cannot be held off; csr_ready is always high. The user is to
// write configuration registers only while no sample is in flight (unenforced).
module ntc_thermistor_to_temperature_core #(
   parameter int ADC_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [11:0]        req_adc_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_data,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_temperature_centi,
   output logic [31:0]        rsp_resistance_ohms,
   output logic               rsp_over_power,
   output logic               rsp_over_current,
   output logic               rsp_out_of_range
);

   localparam int PROD_W    = ADC_BITS + ntc_pkg::UV_W;
   localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
   localparam int FOLDS     = 4;
   localparam int T0_LAT    = FOLDS + 5;
   localparam int RES_LAT   = ntc_pkg::NUM_W + 4;
   localparam int FIN_LAT   = ntc_pkg::LOG_LAT + 4 + ntc_pkg::TNUM_W;
   localparam int RES_PAD   = FIN_LAT - RES_LAT;
   localparam int TOTAL_LAT = T0_LAT + FIN_LAT;
   localparam int BUNDLE_W  = ntc_pkg::RES_W + 2;

   // configuration registers
   logic [ntc_pkg::UV_W-1:0]      vref_uv_ff;
   logic [ntc_pkg::SQ_W-1:0]      vref_sq_ff;
   logic [ntc_pkg::OHM_W-1:0]     series_ff;
   logic [ntc_pkg::OHM_W-1:0]     nominal_ff;
   logic [ntc_pkg::BETA_W-1:0]    beta_ff;
   logic [ntc_pkg::BETA_T_W-1:0]  beta_t_ff;
   logic signed [ntc_pkg::OFFSET_W-1:0] offset_ff;
   logic [ntc_pkg::POWER_W-1:0]   max_power_ff;
   logic [ntc_pkg::CURRENT_W-1:0] max_current_ff;
   logic [ntc_pkg::VREF_W-1:0]    wr_vref;
   logic [ntc_pkg::BETA_W-1:0]    wr_beta;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign wr_vref   = csr_data[ntc_pkg::VREF_W-1:0];
   assign wr_beta   = csr_data[ntc_pkg::BETA_W-1:0];

   // register writes, derived products kept alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         vref_uv_ff     <= ntc_pkg::VREF_UV_RST;
         vref_sq_ff     <= ntc_pkg::VREF_SQ_RST;
         series_ff      <= ntc_pkg::SERIES_RST;
         nominal_ff     <= ntc_pkg::NOMINAL_RST;
         beta_ff        <= ntc_pkg::BETA_RST;
         beta_t_ff      <= ntc_pkg::BETA_T_RST;
         offset_ff      <= ntc_pkg::OFFSET_RST;
         max_power_ff   <= ntc_pkg::POWER_RST;
         max_current_ff <= ntc_pkg::CURRENT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ntc_pkg::CSR_VREF_MV: begin
               vref_uv_ff <= ntc_pkg::UV_W'(wr_vref) * ntc_pkg::UV_W'(ntc_pkg::UV_PER_MV);
               vref_sq_ff <= ntc_pkg::SQ_W'(wr_vref) * ntc_pkg::SQ_W'(wr_vref);
            end
            ntc_pkg::CSR_SERIES:  series_ff  <= csr_data[ntc_pkg::OHM_W-1:0];
            ntc_pkg::CSR_NOMINAL: nominal_ff <= csr_data[ntc_pkg::OHM_W-1:0];
            ntc_pkg::CSR_BETA: begin
               beta_ff   <= wr_beta;
               beta_t_ff <= ntc_pkg::BETA_T_W'(wr_beta) *
                            ntc_pkg::BETA_T_W'(ntc_pkg::T25_CENTI);
            end
            ntc_pkg::CSR_OFFSET:      offset_ff <= csr_data[ntc_pkg::OFFSET_W-1:0];
            ntc_pkg::CSR_MAX_POWER:   max_power_ff <= csr_data[ntc_pkg::POWER_W-1:0];
            ntc_pkg::CSR_MAX_CURRENT: max_current_ff <= csr_data[ntc_pkg::CURRENT_W-1:0];
            default: ;
         endcase
      end
   end

   // request valid travels beside the data
   ntc_delay #(.W(1), .D(TOTAL_LAT)) u_valid (
      .clock (clock), .reset (reset), .d_i (start && !busy), .q_o (rsp_valid)
   );

   // sample scaled to microvolts times full scale
   logic [ADC_BITS-1:0] adc_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   fq_ff [0:FOLDS-1];
   logic [PROD_W-1:0]   fr_ff [0:FOLDS-1];
   logic [PROD_W-1:0]   vq_ff;

   always_ff @(posedge clock) begin
      adc_ff  <= ADC_BITS'(req_adc_sample);
      prod_ff <= PROD_W'(adc_ff) * PROD_W'(vref_uv_ff);
   end

   // divide by 2^ADC_BITS - 1: fold the high part onto the low part, then correct once
   always_ff @(posedge clock) begin
      fq_ff[0] <= prod_ff >> ADC_BITS;
      fr_ff[0] <= PROD_W'(prod_ff[ADC_BITS-1:0]) + (prod_ff >> ADC_BITS);
      for (int k = 1; k < FOLDS; k++) begin
         fq_ff[k] <= fq_ff[k-1] + (fr_ff[k-1] >> ADC_BITS);
         fr_ff[k] <= PROD_W'(fr_ff[k-1][ADC_BITS-1:0]) + (fr_ff[k-1] >> ADC_BITS);
      end
      vq_ff <= (fr_ff[FOLDS-1] >= PROD_W'(FULL_SCALE)) ? fq_ff[FOLDS-1] + PROD_W'(1)
                                                        : fq_ff[FOLDS-1];
   end

   // clamp 10 mV inside the rails, lower bound wins
   logic signed [24:0] vq_s, rail_s, vc1;
   logic [ntc_pkg::UV_W-1:0] v_ff, v_in, vnum_ff, vdiff;
   logic [ntc_pkg::NUM_W-1:0] num_ff, num_in;
   logic [ntc_pkg::OHM_W-1:0] nom;

   always_comb begin
      vq_s   = signed'(25'(vq_ff));
      rail_s = signed'(25'(vref_uv_ff)) - signed'(25'(ntc_pkg::RAIL_UV));
      vc1    = (vq_s > rail_s) ? rail_s : vq_s;
      v_in   = (vc1 < signed'(25'(ntc_pkg::RAIL_UV))) ? ntc_pkg::UV_W'(ntc_pkg::RAIL_UV)
                                                     : ntc_pkg::UV_W'(vc1);
   end

   // ratio numerator series * (vref - v)
   always_comb begin
      vdiff  = vref_uv_ff - v_ff;
      num_in = (vref_uv_ff > v_ff) ? ntc_pkg::NUM_W'(series_ff) * ntc_pkg::NUM_W'(vdiff)
                                   : '0;
      nom    = (nominal_ff == '0) ? ntc_pkg::OHM_W'(1) : nominal_ff;
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      num_ff  <= num_in;
      vnum_ff <= v_ff;
   end

   // logarithms of numerator, voltage and nominal resistance
   logic [ntc_pkg::LOG_W-1:0] ln_num, ln_v, ln_nom;

   ntc_log2 u_log_num (.clock (clock), .x_i (num_ff), .log_o (ln_num));
   ntc_log2 u_log_v   (.clock (clock), .x_i (ntc_pkg::NUM_W'(vnum_ff)), .log_o (ln_v));
   ntc_log2 u_log_nom (.clock (clock), .x_i (ntc_pkg::NUM_W'(nom)), .log_o (ln_nom));

   // Beta denominator
   logic signed [ntc_pkg::LR_W-1:0]       lr_ff;
   logic signed [ntc_pkg::CPROD_W-1:0]    cprod_ff;
   logic signed [ntc_pkg::DEN_CALC_W-1:0] den_calc;
   logic [ntc_pkg::DEN_W-1:0]             den_ff;
   logic hot_d, hot_e3_ff, hot_t;

   ntc_delay #(.W(1), .D(ntc_pkg::LOG_LAT + 2)) u_hot_log (
      .clock (clock), .reset (reset), .d_i (num_ff == '0), .q_o (hot_d)
   );

   assign den_calc = signed'(ntc_pkg::DEN_CALC_W'({beta_ff, 32'b0}))
                   + ntc_pkg::DEN_CALC_W'(cprod_ff);

   always_ff @(posedge clock) begin
      lr_ff     <= signed'(ntc_pkg::LR_W'(ln_num)) - signed'(ntc_pkg::LR_W'(ln_v))
                 - signed'(ntc_pkg::LR_W'(ln_nom));
      cprod_ff  <= signed'(ntc_pkg::CPROD_W'(ntc_pkg::LN2_T25_Q16))
                 * ntc_pkg::CPROD_W'(lr_ff);
      hot_e3_ff <= hot_d || (den_calc <= 0);
      den_ff    <= (den_calc > 0) ? den_calc[ntc_pkg::DEN_W-1:0] : ntc_pkg::DEN_W'(1);
   end

   // absolute temperature quotient
   logic [ntc_pkg::TNUM_W-1:0] tk;

   ntc_divider #(.NUMW(ntc_pkg::TNUM_W), .DVW(ntc_pkg::DEN_W)) u_div_temp (
      .clock (clock), .num_i ({beta_t_ff, 32'b0}), .div_i (den_ff), .quo_o (tk)
   );

   ntc_delay #(.W(1), .D(ntc_pkg::TNUM_W)) u_hot_div (
      .clock (clock), .reset (reset), .d_i (hot_e3_ff), .q_o (hot_t)
   );

   // Celsius, offset, saturation and range check
   logic signed [ntc_pkg::TEMP_W-1:0] temp;
   logic signed [15:0] temp_ff, temp_in;
   logic oor_ff, oor_in;

   always_comb begin
      temp = signed'(ntc_pkg::TEMP_W'(tk)) - ntc_pkg::TEMP_W'(ntc_pkg::KELVIN_CENTI)
           + ntc_pkg::TEMP_W'(offset_ff);
      if (hot_t) begin
         temp_in = 16'sh7FFF;
      end else if (temp > 64'sd32767) begin
         temp_in = 16'sh7FFF;
      end else if (temp < -64'sd32768) begin
         temp_in = -16'sh8000;
      end else begin
         temp_in = temp[15:0];
      end
      oor_in = hot_t || (temp < ntc_pkg::TEMP_W'(ntc_pkg::TEMP_LOW))
                     || (temp > ntc_pkg::TEMP_W'(ntc_pkg::TEMP_HIGH));
   end

   always_ff @(posedge clock) begin
      temp_ff <= temp_in;
      oor_ff  <= oor_in;
   end

   // resistance and the current and power limits
   logic [ntc_pkg::NUM_W-1:0]   rq;
   logic [ntc_pkg::RES_W-1:0]   res_p1_ff, res_p2_ff, res_p3_ff, res_p4_ff;
   logic [ntc_pkg::RSUM_W-1:0]  rsum_p1_ff, rsum_p2_ff;
   logic [ntc_pkg::RSQ_W-1:0]   sq_ff;
   logic [ntc_pkg::LHS_W-1:0]   lhs_ff, lhs_p3_ff;
   logic [ntc_pkg::ILIM_W-1:0]  ilim_ff;
   logic [ntc_pkg::PPART_W-1:0] phi_ff, plo_ff;
   logic [ntc_pkg::RHS_W-1:0]   rhs;
   logic rnz_p3_ff, oc_p3_ff, oc_p4_ff, op_p4_ff;
   logic [BUNDLE_W-1:0] bundle;

   ntc_divider #(.NUMW(ntc_pkg::NUM_W), .DVW(ntc_pkg::UV_W)) u_div_res (
      .clock (clock), .num_i (num_ff), .div_i (vnum_ff), .quo_o (rq)
   );

   assign rhs = {phi_ff, {ntc_pkg::RSUM_W{1'b0}}} + ntc_pkg::RHS_W'(plo_ff);

   always_ff @(posedge clock) begin
      res_p1_ff  <= rq[ntc_pkg::RES_W-1:0];
      rsum_p1_ff <= ntc_pkg::RSUM_W'(series_ff) + ntc_pkg::RSUM_W'(rq[ntc_pkg::RES_W-1:0]);

      res_p2_ff  <= res_p1_ff;
      rsum_p2_ff <= rsum_p1_ff;
      sq_ff      <= ntc_pkg::RSQ_W'(rsum_p1_ff) * ntc_pkg::RSQ_W'(rsum_p1_ff);
      lhs_ff     <= ntc_pkg::LHS_W'(vref_sq_ff) * ntc_pkg::LHS_W'(res_p1_ff);
      ilim_ff    <= ntc_pkg::ILIM_W'(max_current_ff) * ntc_pkg::ILIM_W'(rsum_p1_ff);

      res_p3_ff  <= res_p2_ff;
      lhs_p3_ff  <= lhs_ff;
      rnz_p3_ff  <= (rsum_p2_ff != '0);
      oc_p3_ff   <= (rsum_p2_ff == '0) || (ntc_pkg::ILIM_W'(vref_uv_ff) > ilim_ff);
      phi_ff     <= ntc_pkg::PPART_W'(max_power_ff)
                  * ntc_pkg::PPART_W'(sq_ff[ntc_pkg::RSQ_W-1:ntc_pkg::RSUM_W]);
      plo_ff     <= ntc_pkg::PPART_W'(max_power_ff)
                  * ntc_pkg::PPART_W'(sq_ff[ntc_pkg::RSUM_W-1:0]);

      res_p4_ff  <= res_p3_ff;
      oc_p4_ff   <= oc_p3_ff;
      op_p4_ff   <= rnz_p3_ff && (ntc_pkg::RHS_W'(lhs_p3_ff) > rhs);
   end

   ntc_delay #(.W(BUNDLE_W), .D(RES_PAD)) u_res_pad (
      .clock (clock), .reset (reset),
      .d_i   ({res_p4_ff, op_p4_ff, oc_p4_ff}), .q_o (bundle)
   );

   // result ports
   assign rsp_temperature_centi = temp_ff;
   assign rsp_out_of_range      = oor_ff;
   assign rsp_resistance_ohms   = 32'(bundle[BUNDLE_W-1:2]);
   assign rsp_over_power        = bundle[1];
   assign rsp_over_current      = bundle[0];

endmodule
